FILE: rtl/lz4bsd_pkg.sv
// Shared types and constants for the LZ4 block stream decoder.
package lz4bsd_pkg;

  localparam int unsigned WINDOW_BYTES = 65536;
  localparam int unsigned LENGTH_BITS  = 32;
  localparam int unsigned WP_W         = $clog2(WINDOW_BYTES);
  localparam int unsigned BP_W         = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned CMP_W        = 17;
  localparam int unsigned SUM_W        = LENGTH_BITS + 1;
  localparam int unsigned MIN_MATCH    = 4;
  localparam int unsigned NIBBLE_MAX   = 15;
  localparam int unsigned EXT_CONT     = 255;
  localparam int unsigned OQ_DEPTH     = 3;
  localparam int unsigned OQ_PTR_W     = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W     = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_PULL = 2'd1,
    KIND_END  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_TOKEN     = 3'd0,
    PH_LIT_EXT   = 3'd1,
    PH_LITERALS  = 3'd2,
    PH_OFF_LO    = 3'd3,
    PH_OFF_HI    = 3'd4,
    PH_MATCH_EXT = 3'd5,
    PH_COPY      = 3'd6,
    PH_DONE      = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_OFFSET       = 3'd1,
    ERR_MIDSEQ       = 3'd2,
    ERR_OVERFLOW     = 3'd3,
    ERR_BYTE_IN_COPY = 3'd4
  } err_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       copy_pending;
    logic       done_res;
    logic [2:0] error_code;
  } out_t;

  // Work carried from the accept edge to the result stage.
  typedef struct packed {
    logic            valid;
    logic            has_result;
    logic            from_hist;
    logic            fwd;
    logic            wr;
    logic [WP_W-1:0] waddr;
    logic [7:0]      lit_byte;
    logic            byte_valid;
    logic            copy_pending;
    logic            done_res;
    logic [2:0]      error_code;
  } stage_t;

endpackage

FILE: rtl/lz4bsd_ram.sv
// Generic simple dual-port RAM with registered, read-first read port.
module lz4bsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lz4_block_stream_decoder_core.sv
// Top level of the LZ4 block stream decoder: parser, history ring and result queue.
//
//  channel | signals                         | moves
//  --------+---------------------------------+-------------------------------------
//  input   | in_valid, in_ready, in_data     | one compressed byte, pull or end
//  output  | out_valid, out_ready, out_data  | zero or one result per input transfer
//
// One input transfer per cycle while the result queue has room. An item's result
// passes through the result stage, which covers the history RAM read, and then the
// result queue before it can transfer out.
// Reset (rst, synchronous) clears parser state, counters and the queue; the history
// RAM is not cleared and the offset check keeps unwritten entries from being read.
// A stalled output fills a three-entry result queue; in_ready drops once the queue
// plus the item in flight could not take another result.
module lz4_block_stream_decoder_core
  import lz4bsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Parser state.
  phase_t                 phase, phase_next;
  err_t                   sticky, sticky_next;
  logic [3:0]             match_nib, match_nib_next;
  logic [LENGTH_BITS-1:0] lit_left, lit_left_next;
  logic [LENGTH_BITS-1:0] match_left, match_left_next;
  logic [15:0]            match_offset, match_offset_next;
  logic [WP_W-1:0]        wp, wp_next;
  logic [BP_W-1:0]        bp, bp_next;

  // Result stage and queue.
  stage_t                 s1, s1_next;
  logic [7:0]             prev_byte;
  logic [7:0]             s1_byte;
  logic [7:0]             ram_q;
  out_t                   oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]    head, tail;
  logic [OQ_CNT_W-1:0]    count;

  logic                   accept;
  kind_t                  kind;
  logic [7:0]             b;
  logic                   frozen;
  logic                   put;
  logic                   rd;
  logic                   emit;
  logic [SUM_W-1:0]       lit_sum;
  logic [SUM_W-1:0]       match_sum;
  logic [15:0]            off_full;
  logic [CMP_W-1:0]       wp_ext, off_ext, idx_ext;
  logic [WP_W-1:0]        rd_idx;
  logic                   push, pop;

  assign accept = in_valid && in_ready;
  assign kind   = kind_t'(in_data.kind);
  assign b      = in_data.in_byte;
  assign frozen = (sticky != ERR_NONE) || (phase == PH_DONE);

  // Length arithmetic: one spare bit catches overflow past the counter width.
  assign lit_sum   = {1'b0, lit_left} + SUM_W'(b);
  assign match_sum = {1'b0, match_left} + SUM_W'(b) + SUM_W'(MIN_MATCH);
  assign off_full  = {b, match_offset[7:0]};

  // Source of a copied byte: offset back from the write pointer, around the ring.
  assign wp_ext  = CMP_W'(wp);
  assign off_ext = CMP_W'(match_offset);
  assign idx_ext = (wp_ext >= off_ext) ? (wp_ext - off_ext)
                                       : (wp_ext + CMP_W'(WINDOW_BYTES) - off_ext);
  assign rd_idx  = idx_ext[WP_W-1:0];

  // Next state of the parser.
  always_comb begin
    phase_next        = phase;
    sticky_next       = sticky;
    match_nib_next    = match_nib;
    lit_left_next     = lit_left;
    match_left_next   = match_left;
    match_offset_next = match_offset;
    wp_next           = wp;
    bp_next           = bp;
    put               = 1'b0;
    rd                = 1'b0;
    emit              = 1'b0;

    if (accept && kind != KIND_NONE) begin
      if (frozen) begin
        emit = 1'b1;
      end else begin
        unique case (kind)
          KIND_END: begin
            emit = 1'b1;
            if (phase == PH_OFF_LO && match_nib == 4'd0) begin
              phase_next = PH_DONE;
            end else begin
              sticky_next = ERR_MIDSEQ;
            end
          end
          KIND_PULL: begin
            emit = 1'b1;
            if (phase == PH_COPY) begin
              put             = 1'b1;
              rd              = 1'b1;
              match_left_next = match_left - LENGTH_BITS'(1);
              if (match_left == LENGTH_BITS'(1)) begin
                phase_next = PH_TOKEN;
              end
            end
          end
          KIND_BYTE: begin
            unique case (phase)
              PH_TOKEN: begin
                match_nib_next = b[3:0];
                lit_left_next  = LENGTH_BITS'(b[7:4]);
                if (b[7:4] == 4'(NIBBLE_MAX)) begin
                  phase_next = PH_LIT_EXT;
                end else if (b[7:4] != 4'd0) begin
                  phase_next = PH_LITERALS;
                end else begin
                  phase_next = PH_OFF_LO;
                end
              end
              PH_LIT_EXT: begin
                if (lit_sum[LENGTH_BITS]) begin
                  sticky_next = ERR_OVERFLOW;
                  emit        = 1'b1;
                end else begin
                  lit_left_next = lit_sum[LENGTH_BITS-1:0];
                  if (b != 8'(EXT_CONT)) begin
                    phase_next = PH_LITERALS;
                  end
                end
              end
              PH_LITERALS: begin
                put           = 1'b1;
                emit          = 1'b1;
                lit_left_next = lit_left - LENGTH_BITS'(1);
                if (lit_left == LENGTH_BITS'(1)) begin
                  phase_next = PH_OFF_LO;
                end
              end
              PH_OFF_LO: begin
                match_offset_next = {8'd0, b};
                phase_next        = PH_OFF_HI;
              end
              PH_OFF_HI: begin
                match_offset_next = off_full;
                if (off_full == 16'd0 || CMP_W'(off_full) > CMP_W'(bp)) begin
                  sticky_next = ERR_OFFSET;
                  emit        = 1'b1;
                end else if (match_nib == 4'(NIBBLE_MAX)) begin
                  match_left_next = LENGTH_BITS'(match_nib);
                  phase_next      = PH_MATCH_EXT;
                end else begin
                  // A nibble plus the minimum match always fits the counter.
                  match_left_next = LENGTH_BITS'(match_nib) + LENGTH_BITS'(MIN_MATCH);
                  phase_next      = PH_COPY;
                  emit            = 1'b1;
                end
              end
              PH_MATCH_EXT: begin
                if (match_sum[LENGTH_BITS]) begin
                  sticky_next = ERR_OVERFLOW;
                  emit        = 1'b1;
                end else if (b == 8'(EXT_CONT)) begin
                  match_left_next = match_left + LENGTH_BITS'(EXT_CONT);
                end else begin
                  match_left_next = match_sum[LENGTH_BITS-1:0];
                  phase_next      = PH_COPY;
                  emit            = 1'b1;
                end
              end
              PH_COPY: begin
                sticky_next = ERR_BYTE_IN_COPY;
                emit        = 1'b1;
              end
              PH_DONE: begin
                emit = 1'b1;
              end
            endcase
          end
          KIND_NONE: begin
          end
        endcase
      end
    end

    // Advance the ring pointer and the saturating byte count.
    if (put) begin
      wp_next = (wp_ext + CMP_W'(1) >= CMP_W'(WINDOW_BYTES)) ? '0 : wp + WP_W'(1);
      if (CMP_W'(bp) < CMP_W'(WINDOW_BYTES)) begin
        bp_next = bp + BP_W'(1);
      end
    end
  end

  // Load of the result stage.
  always_comb begin
    s1_next              = '0;
    s1_next.valid        = emit || put;
    s1_next.has_result   = emit;
    s1_next.from_hist    = rd;
    // Read-first RAM misses the byte being written at this same edge: forward it.
    s1_next.fwd          = s1.valid && s1.wr && (s1.waddr == rd_idx);
    s1_next.wr           = put;
    s1_next.waddr        = wp;
    s1_next.lit_byte     = b;
    s1_next.byte_valid   = put;
    s1_next.copy_pending = (sticky_next == ERR_NONE) && (phase_next == PH_COPY);
    s1_next.done_res     = (sticky_next == ERR_NONE) && (phase_next == PH_DONE);
    s1_next.error_code   = sticky_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TOKEN;
      sticky       <= ERR_NONE;
      match_nib    <= '0;
      lit_left     <= '0;
      match_left   <= '0;
      match_offset <= '0;
      wp           <= '0;
      bp           <= '0;
      s1           <= '0;
    end else begin
      phase        <= phase_next;
      sticky       <= sticky_next;
      match_nib    <= match_nib_next;
      lit_left     <= lit_left_next;
      match_left   <= match_left_next;
      match_offset <= match_offset_next;
      wp           <= wp_next;
      bp           <= bp_next;
      s1           <= s1_next;
    end
  end

  lz4bsd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk   (clk),
    .we    (s1.valid && s1.wr),
    .waddr (s1.waddr),
    .wdata (s1_byte),
    .re    (rd),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  // Resolve the byte of the item in the result stage.
  assign s1_byte = s1.from_hist ? (s1.fwd ? prev_byte : ram_q) : s1.lit_byte;

  always_ff @(posedge clk) begin
    prev_byte <= s1_byte;
  end

  // Result queue.
  assign push      = s1.valid && s1.has_result;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = oq[head];
  assign in_ready  = !rst &&
                     ((3'(count) + 3'(s1.valid)) <= 3'(OQ_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (push) begin
      oq[tail].out_byte     <= s1.byte_valid ? s1_byte : 8'd0;
      oq[tail].out_valid    <= s1.byte_valid;
      oq[tail].copy_pending <= s1.copy_pending;
      oq[tail].done_res     <= s1.done_res;
      oq[tail].error_code   <= s1.error_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : tail + OQ_PTR_W'(1);
      end
      if (pop) begin
        head <= (head == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : head + OQ_PTR_W'(1);
      end
      count <= count + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overfilled");

  a_copy_len : assert property (@(posedge clk) disable iff (rst)
    phase == PH_COPY |-> match_left != '0)
    else $error("copy phase with no match bytes left");

  a_frozen : assert property (@(posedge clk) disable iff (rst)
    sticky != ERR_NONE |=> (phase == $past(phase) && wp == $past(wp) && sticky == $past(sticky)))
    else $error("state moved after an error");

  a_ring_bounds : assert property (@(posedge clk) disable iff (rst)
    CMP_W'(bp) <= CMP_W'(WINDOW_BYTES) && CMP_W'(wp) < CMP_W'(WINDOW_BYTES))
    else $error("ring pointer or byte count out of range");

  a_hist_read : assert property (@(posedge clk) disable iff (rst)
    rd |=> (s1.valid && s1.from_hist && s1.has_result))
    else $error("history read without a copy result in the stage");

endmodule

FILE: verif/lz4bsd_result_check.sv
// Result checker for the LZ4 block stream decoder: predicts every result and compares it.
`timescale 1ns / 1ps
module lz4bsd_result_check
  import lz4bsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  localparam int unsigned LW = LENGTH_BITS + 2;
  localparam logic [LW-1:0] LEN_LIMIT = {2'b00, {LENGTH_BITS{1'b1}}};
  localparam int REPORT_MAX = 10;

  phase_t          ph;
  logic [3:0]      match_nib;
  logic [LW-1:0]   lit_left;
  logic [LW-1:0]   copy_left;
  logic [15:0]     copy_dist;
  logic [WP_W-1:0] wr_ptr;
  logic [BP_W-1:0] produced;
  logic [7:0]      ring [WINDOW_BYTES];
  err_t            err;
  out_t            expected_results [$];
  int              fails = 0;

  function automatic void store_byte(logic [7:0] b);
    ring[wr_ptr] = b;
    wr_ptr = (int'(wr_ptr) + 1 >= WINDOW_BYTES) ? '0 : wr_ptr + 1'b1;
    if (produced < WINDOW_BYTES) produced = produced + 1'b1;
  endfunction

  function automatic out_t make_result(logic [7:0] b, logic v);
    out_t r;
    r.out_byte     = b;
    r.out_valid    = v;
    r.copy_pending = (err == ERR_NONE) && (ph == PH_COPY);
    r.done_res     = (err == ERR_NONE) && (ph == PH_DONE);
    r.error_code   = err;
    return r;
  endfunction

  // Advance the decoder state by one transfer; return 1 when it yields a result.
  function automatic bit decode_item(in_t item, output out_t res);
    logic [7:0]  b;
    logic [7:0]  v;
    int unsigned idx;
    b   = item.in_byte;
    res = '0;
    if (item.kind == KIND_NONE) return 1'b0;
    if (err != ERR_NONE || ph == PH_DONE) begin
      res = make_result(8'h00, 1'b0);
      return 1'b1;
    end
    if (item.kind == KIND_END) begin
      if (ph == PH_OFF_LO && match_nib == 4'd0) ph = PH_DONE;
      else err = ERR_MIDSEQ;
      res = make_result(8'h00, 1'b0);
      return 1'b1;
    end
    if (item.kind == KIND_PULL) begin
      if (ph != PH_COPY) begin
        res = make_result(8'h00, 1'b0);
        return 1'b1;
      end
      idx = (int'(wr_ptr) >= int'(copy_dist)) ? wr_ptr - copy_dist
                                              : wr_ptr + WINDOW_BYTES - copy_dist;
      v = ring[idx % WINDOW_BYTES];
      store_byte(v);
      copy_left = copy_left - 1'b1;
      if (copy_left == '0) ph = PH_TOKEN;
      res = make_result(v, 1'b1);
      return 1'b1;
    end
    case (ph)
      PH_TOKEN: begin
        match_nib = b[3:0];
        lit_left  = b[7:4];
        if (b[7:4] == NIBBLE_MAX) ph = PH_LIT_EXT;
        else if (b[7:4] != 4'd0) ph = PH_LITERALS;
        else ph = PH_OFF_LO;
        return 1'b0;
      end
      PH_LIT_EXT: begin
        lit_left = lit_left + b;
        if (lit_left > LEN_LIMIT) begin
          err = ERR_OVERFLOW;
          res = make_result(8'h00, 1'b0);
          return 1'b1;
        end
        if (b != EXT_CONT) ph = PH_LITERALS;
        return 1'b0;
      end
      PH_LITERALS: begin
        store_byte(b);
        lit_left = lit_left - 1'b1;
        if (lit_left == '0) ph = PH_OFF_LO;
        res = make_result(b, 1'b1);
        return 1'b1;
      end
      PH_OFF_LO: begin
        copy_dist = {8'h00, b};
        ph = PH_OFF_HI;
        return 1'b0;
      end
      PH_OFF_HI: begin
        copy_dist[15:8] = b;
        if (copy_dist == 16'd0 || copy_dist > produced) begin
          err = ERR_OFFSET;
          res = make_result(8'h00, 1'b0);
          return 1'b1;
        end
        copy_left = match_nib;
        if (match_nib == NIBBLE_MAX) begin
          ph = PH_MATCH_EXT;
          return 1'b0;
        end
        copy_left = copy_left + MIN_MATCH;
        if (copy_left > LEN_LIMIT) begin
          err = ERR_OVERFLOW;
          res = make_result(8'h00, 1'b0);
          return 1'b1;
        end
        ph = PH_COPY;
        res = make_result(8'h00, 1'b0);
        return 1'b1;
      end
      PH_MATCH_EXT: begin
        copy_left = copy_left + b;
        if (b == EXT_CONT) begin
          if (copy_left + MIN_MATCH > LEN_LIMIT) begin
            err = ERR_OVERFLOW;
            res = make_result(8'h00, 1'b0);
            return 1'b1;
          end
          return 1'b0;
        end
        copy_left = copy_left + MIN_MATCH;
        if (copy_left > LEN_LIMIT) begin
          err = ERR_OVERFLOW;
          res = make_result(8'h00, 1'b0);
          return 1'b1;
        end
        ph = PH_COPY;
        res = make_result(8'h00, 1'b0);
        return 1'b1;
      end
      PH_COPY: begin
        err = ERR_BYTE_IN_COPY;
        res = make_result(8'h00, 1'b0);
        return 1'b1;
      end
      default: begin
        res = make_result(8'h00, 1'b0);
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    out_t got;
    bit   has;
    if (rst) begin
      ph        = PH_TOKEN;
      match_nib = '0;
      lit_left  = '0;
      copy_left = '0;
      copy_dist = '0;
      wr_ptr    = '0;
      produced  = '0;
      err       = ERR_NONE;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        has = decode_item(in_data, want);
        if (has) expected_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("%0t: unexpected result byte=%02h valid=%b copy=%b done=%b err=%0d",
                     $realtime, got.out_byte, got.out_valid, got.copy_pending,
                     got.done_res, got.error_code);
        end else begin
          want = expected_results.pop_front();
          if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
              got.copy_pending !== want.copy_pending || got.done_res !== want.done_res ||
              got.error_code !== want.error_code) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display("%0t: mismatch expected byte=%02h valid=%b copy=%b done=%b err=%0d",
                       $realtime, want.out_byte, want.out_valid, want.copy_pending,
                       want.done_res, want.error_code, " got byte=%02h valid=%b copy=%b",
                       got.out_byte, got.out_valid, got.copy_pending,
                       " done=%b err=%0d", got.done_res, got.error_code);
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_results.size();
  end

endmodule

FILE: verif/tb_lz4_block_stream_decoder_core.sv
// Testbench top for the LZ4 block stream decoder: stimulus, output pacing and verdict.
`timescale 1ns / 1ps
module tb_lz4_block_stream_decoder_core;
  import lz4bsd_pkg::*;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 16;

  // How the compressed stream is closed; the decoder freezes after any of these.
  typedef enum int {
    END_CLEAN,
    END_ZERO_OFFSET,
    END_FAR_OFFSET,
    END_MIDSEQ,
    END_BYTE_IN_COPY
  } stream_end_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;

  int produced_bytes = 0;  // bytes decoded so far, saturating at the window size
  int items_sent     = 0;  // transfers of kinds that the decoder acts on
  int burst_left     = 0;
  bit no_gaps        = 1'b0;
  bit rx_hold_req    = 1'b0;
  bit rx_holding     = 1'b0;
  int idle_cycles    = 0;

  always #4 clk = ~clk;

  lz4_block_stream_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lz4bsd_result_check result_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: end the run once no transfer has happened on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sender gap: mostly none or short, a few long, with occasional gapless bursts.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and hold it until the transfer. Returns at the accepting edge, with
  // valid still high, so a back-to-back item needs only one assignment in that step.
  task automatic send_item(kind_t k, logic [7:0] b);
    int   gap;
    in_t  item;
    gap          = pick_gap();
    item.kind    = k;
    item.in_byte = b;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k != KIND_NONE) items_sent++;
  endtask

  task automatic note_produced(int n);
    produced_bytes = produced_bytes + n;
    if (produced_bytes > WINDOW_BYTES) produced_bytes = WINDOW_BYTES;
  endtask

  // Sprinkle ignored items anywhere, and pulls with nothing to copy outside a match.
  task automatic maybe_noise(bit in_copy);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) send_item(KIND_NONE, 8'($urandom));
    else if (r < 8 && !in_copy) send_item(KIND_PULL, 8'($urandom));
  endtask

  // Length extension: a run of 255 bytes closed by one byte below 255.
  task automatic send_len_ext(int rest);
    while (rest >= EXT_CONT) begin
      send_item(KIND_BYTE, 8'(EXT_CONT));
      rest -= EXT_CONT;
    end
    send_item(KIND_BYTE, 8'(rest));
  endtask

  // Offsets: mostly short so copies overlap their own output, sometimes anywhere back.
  function automatic int pick_dist();
    int reach;
    reach = (produced_bytes > 65535) ? 65535 : produced_bytes;
    if ($urandom_range(0, 3) != 0) return $urandom_range(1, (reach < 8) ? reach : 8);
    return $urandom_range(1, reach);
  endfunction

  // One well-formed sequence. A match length of zero closes the block: no offset follows
  // and the next item must be the end. An offset of zero picks one at random.
  task automatic send_sequence(int n_lit, int match_len, int offset);
    logic [3:0] lit_nib;
    logic [3:0] ml_nib;
    lit_nib = (n_lit >= NIBBLE_MAX) ? 4'(NIBBLE_MAX) : 4'(n_lit);
    ml_nib  = (match_len == 0) ? 4'd0 :
              (match_len - MIN_MATCH >= NIBBLE_MAX) ? 4'(NIBBLE_MAX) : 4'(match_len - MIN_MATCH);
    send_item(KIND_BYTE, {lit_nib, ml_nib});
    maybe_noise(1'b0);
    if (lit_nib == NIBBLE_MAX) send_len_ext(n_lit - NIBBLE_MAX);
    for (int i = 0; i < n_lit; i++) begin
      send_item(KIND_BYTE, 8'($urandom));
      maybe_noise(1'b0);
    end
    note_produced(n_lit);
    if (match_len == 0) return;
    if (offset <= 0) offset = pick_dist();
    send_item(KIND_BYTE, offset[7:0]);
    maybe_noise(1'b0);
    send_item(KIND_BYTE, offset[15:8]);
    if (ml_nib == NIBBLE_MAX) send_len_ext(match_len - MIN_MATCH - NIBBLE_MAX);
    for (int i = 0; i < match_len; i++) begin
      send_item(KIND_PULL, 8'($urandom));
      maybe_noise(1'b1);
    end
    note_produced(match_len);
  endtask

  task automatic random_sequence();
    int r;
    int n_lit;
    int mlen;
    r = $urandom_range(0, 99);
    if (r < 70) n_lit = $urandom_range(0, 14);
    else if (r < 85) n_lit = NIBBLE_MAX;
    else if (r < 96) n_lit = $urandom_range(16, 40);
    else if (r < 99) n_lit = $urandom_range(269, 272);  // straddle a 255 in the chain
    else n_lit = $urandom_range(524, 527);
    r = $urandom_range(0, 99);
    if (r < 70) mlen = $urandom_range(4, 18);
    else if (r < 85) mlen = 19;
    else if (r < 97) mlen = $urandom_range(20, 60);
    else mlen = $urandom_range(273, 276);
    if (produced_bytes == 0 && n_lit == 0) n_lit = 1;
    send_sequence(n_lit, mlen, 0);
  endtask

  // Hold valid low until every expected result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Ask the receiver for a long hold and keep offering pulls so the queue backs up.
  task automatic squeeze_output();
    rx_hold_req = 1'b1;
    no_gaps     = 1'b1;
    while (!rx_holding) send_item(KIND_PULL, 8'($urandom));
    while (rx_holding) send_item(KIND_PULL, 8'($urandom));
    no_gaps = 1'b0;
  endtask

  task automatic finish_stream(stream_end_t how);
    case (how)
      END_CLEAN: begin
        send_sequence($urandom_range(0, 5), 0, 0);
        send_item(KIND_END, 8'($urandom));
      end
      END_ZERO_OFFSET: begin
        send_item(KIND_BYTE, 8'h14);
        send_item(KIND_BYTE, 8'($urandom));
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h00);
      end
      END_FAR_OFFSET: begin
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'(produced_bytes + 1));
        send_item(KIND_BYTE, 8'((produced_bytes + 1) >> 8));
      end
      END_MIDSEQ: begin
        case ($urandom_range(0, 6))
          0: ;  // right where a token is due
          1: send_item(KIND_BYTE, 8'h30);
          2: send_item(KIND_BYTE, 8'hF0);
          3: send_item(KIND_BYTE, 8'h05);
          4: begin
            send_item(KIND_BYTE, 8'h04);
            send_item(KIND_BYTE, 8'h01);
          end
          5: begin
            send_item(KIND_BYTE, 8'h0F);
            send_item(KIND_BYTE, 8'h01);
            send_item(KIND_BYTE, 8'h00);
          end
          default: begin
            send_item(KIND_BYTE, 8'h05);
            send_item(KIND_BYTE, 8'h01);
            send_item(KIND_BYTE, 8'h00);
            send_item(KIND_PULL, 8'($urandom));
          end
        endcase
        send_item(KIND_END, 8'($urandom));
      end
      default: begin
        send_item(KIND_BYTE, 8'h05);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_PULL, 8'($urandom));
        send_item(KIND_BYTE, 8'($urandom));
      end
    endcase
  endtask

  // Receiver pacing: long ready stretches, short and long stalls, and one forced hold.
  initial begin : receiver
    int r;
    int len;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_holding  = 1'b1;
        out_ready  <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          out_ready <= 1'b1;
          len = $urandom_range(100, 300);
        end else if (r < 60) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 90) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else if (r < 98) begin
          out_ready <= 1'b0;
          len = $urandom_range(4, 12);
        end else begin
          out_ready <= 1'b0;
          len = $urandom_range(20, 50);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    stream_end_t how;
    bit          squeezed;
    bit          paused;
    how      = stream_end_t'($urandom_range(0, 4));
    squeezed = 1'b0;
    paused   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: an ignored item, a pull before any copy, extreme literals, an overlapping
    // copy at offset one, then an empty-literal sequence reaching back to the first byte.
    send_item(KIND_NONE, 8'hFF);
    send_item(KIND_PULL, 8'h00);
    send_item(KIND_BYTE, 8'h20);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'h01);
    send_item(KIND_BYTE, 8'h00);
    repeat (4) send_item(KIND_PULL, 8'hFF);
    note_produced(6);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'h06);
    send_item(KIND_BYTE, 8'h00);
    repeat (4) send_item(KIND_PULL, 8'h00);
    note_produced(4);
    send_item(KIND_PULL, 8'hFF);
    wait_drained();

    // Random sequences, with one backed-up output and one full drain along the way.
    while (items_sent < RANDOM_ITEMS) begin
      random_sequence();
      if (!squeezed && items_sent > 400) begin
        squeeze_output();
        squeezed = 1'b1;
      end
      if (!paused && items_sent > 800) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    // Reach back to the oldest byte produced, then a few more sequences.
    send_sequence(1, 4, produced_bytes + 1);
    repeat (5) random_sequence();
    wait_drained();

    finish_stream(how);
    // The decoder is frozen now; every acted-on item still yields a result.
    repeat (12) send_item(kind_t'($urandom_range(0, 3)), 8'($urandom));

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
